// File: rtl/core/dats_pkg.sv
package dats_pkg;

    // Field widths of the command and sample channels.
    localparam int FUNC_W     = 2;
    localparam int VOLUME_W   = 8;
    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 2;
    localparam int PHASE_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int SEG_W      = 3;
    localparam int REPEAT_W   = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_REPEATS = 2'd2;

    localparam logic [COUNT_W-1:0]  BEEP_LENGTH_RST   = 16'd20000;
    localparam logic [PHASE_W-1:0]  BEEP_STEP_RST     = 16'd750;
    localparam logic [REPEAT_W-1:0] ALARM_REPEATS_RST = 8'h7F;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALARM = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BEEP  = 2'd2;

    // Segments in one pass of the alarm sequence (1 to 8).
    localparam int NUM_SEGMENTS = 6;

    // One tick on its way from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
        logic [GAIN_W-1:0]  gain;
        logic               sounding;
        logic               last;
    } tick_t;

    function automatic logic [COUNT_W-1:0] seg_length(input logic [SEG_W-1:0] idx);
        logic [COUNT_W-1:0] len;
        case (idx)
            3'd0:    len = 16'd65000;
            3'd1:    len = 16'd45000;
            3'd2:    len = 16'd35000;
            3'd3:    len = 16'd25000;
            default: len = 16'd65000;
        endcase
        return len;
    endfunction

    function automatic logic [PHASE_W-1:0] seg_step(input logic [SEG_W-1:0] idx);
        logic [PHASE_W-1:0] step;
        case (idx)
            3'd0:    step = 16'd700;
            3'd1:    step = 16'd950;
            3'd2:    step = 16'd750;
            3'd3:    step = 16'd1150;
            default: step = 16'd0;
        endcase
        return step;
    endfunction

    // Gain falls by one step every 32 passes, starting at full gain.
    function automatic logic [GAIN_W-1:0] alarm_gain(input logic [REPEAT_W-1:0] rep);
        return ~rep[6:5];
    endfunction

    // One entry of the sine table, evaluated at elaboration only. The
    // rounded quotient is formed by shift and subtract.
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned a,
                                                       input int unsigned abits);
        longint unsigned half;
        longint unsigned t;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned dvd;
        longint unsigned dvs;
        longint unsigned quo;
        longint unsigned rem;
        int i;
        half = 64'd1 << (abits - 1);
        t    = longint'(a) & (half - 64'd1);
        p    = t * (half - t);
        num  = 64'd2032 * p;
        den  = 64'd5 * half * half - 64'd4 * p;
        dvd  = 64'd2 * num + den;
        dvs  = 64'd2 * den;
        quo  = 64'd0;
        rem  = 64'd0;
        for (i = 39; i >= 0; i--) begin
            rem = (rem << 1) | ((dvd >> i) & 64'd1);
            if (rem >= dvs) begin
                rem = rem - dvs;
                quo = quo | (64'd1 << i);
            end
        end
        if (quo > 64'd127) begin
            quo = 64'd127;
        end
        if (longint'(a) < half) begin
            return SAMPLE_W'(64'd128 + quo);
        end
        return SAMPLE_W'(64'd128 - quo);
    endfunction

endpackage

// File: rtl/core/dats_if.sv
interface dats_in_if import dats_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [VOLUME_W-1:0] volume;
    logic                abort_key;

    modport source (output valid, output func, output volume, output abort_key,
                    input ready);
    modport sink   (input valid, input func, input volume, input abort_key,
                    output ready);
endinterface

interface dats_out_if import dats_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]   gain;
    logic                sounding;
    logic                last;

    modport source (output valid, output sample, output gain, output sounding,
                    output last, input ready);
    modport sink   (input valid, input sample, input gain, input sounding,
                    input last, output ready);
endinterface

// File: rtl/core/dats_seq.sv
module dats_seq import dats_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  advance,
    input  logic [FUNC_W-1:0]     func,
    input  logic [VOLUME_W-1:0]   volume,
    input  logic                  abort_key,
    output tick_t                 tick
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ALARM = 2'd1,
        MODE_BEEP  = 2'd2
    } play_mode_t;

    logic [COUNT_W-1:0]  beep_length_reg;
    logic [PHASE_W-1:0]  beep_step_reg;
    logic [REPEAT_W-1:0] alarm_repeats_reg;

    play_mode_t          mode_reg, mode_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [COUNT_W-1:0]  samples_left_reg, samples_left_next;
    logic [SEG_W-1:0]    segment_reg, segment_next;
    logic [REPEAT_W-1:0] repeat_reg, repeat_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    tick_t               tick_reg, tick_next;

    logic [PHASE_W-1:0]  step;
    logic [PHASE_W-1:0]  phase_sum;
    logic [COUNT_W-1:0]  count_dec;
    logic [SEG_W:0]      seg_sum;
    logic [SEG_W-1:0]    seg_new;
    logic [REPEAT_W-1:0] rep_new;
    logic                last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_length_reg   <= BEEP_LENGTH_RST;
            beep_step_reg     <= BEEP_STEP_RST;
            alarm_repeats_reg <= ALARM_REPEATS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BEEP_LENGTH:   beep_length_reg   <= cfg_data;
                CFG_BEEP_STEP:     beep_step_reg     <= cfg_data;
                CFG_ALARM_REPEATS: alarm_repeats_reg <= cfg_data[REPEAT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        phase_next        = phase_reg;
        samples_left_next = samples_left_reg;
        segment_next      = segment_reg;
        repeat_next       = repeat_reg;
        gain_next         = gain_reg;
        tick_next         = tick_reg;
        if (advance)
        begin
            tick_next.valid = 1'b0;
        end

        step      = (mode_reg == MODE_ALARM) ? seg_step(segment_reg) : beep_step_reg;
        phase_sum = phase_reg + step;
        count_dec = samples_left_reg - 16'd1;
        seg_sum   = {1'b0, segment_reg} + 4'd1;
        seg_new   = segment_reg;
        rep_new   = repeat_reg;
        last      = 1'b0;

        if (accept)
        begin
            case (func)
                FUNC_ALARM:
                begin
                    if (alarm_repeats_reg != '0)
                    begin
                        mode_next         = MODE_ALARM;
                        phase_next        = '0;
                        segment_next      = '0;
                        repeat_next       = '0;
                        samples_left_next = seg_length(3'd0);
                        gain_next         = alarm_gain(8'd0);
                    end
                end
                FUNC_BEEP:
                begin
                    if (volume != '0 && beep_length_reg != '0)
                    begin
                        mode_next         = MODE_BEEP;
                        phase_next        = '0;
                        samples_left_next = beep_length_reg;
                        gain_next         = ~(volume[GAIN_W-1:0] - 2'd1);
                    end
                end
                FUNC_TICK:
                begin
                    tick_next.valid = 1'b1;
                    case (mode_reg)
                        MODE_ALARM, MODE_BEEP:
                        begin
                            phase_next         = phase_sum;
                            tick_next.phase    = phase_sum;
                            tick_next.gain     = gain_reg;
                            tick_next.sounding = 1'b1;
                            if (mode_reg == MODE_ALARM)
                            begin
                                if (abort_key)
                                begin
                                    last = 1'b1;
                                end
                                else
                                begin
                                    samples_left_next = count_dec;
                                    if (count_dec == '0)
                                    begin
                                        // Segment finished: move on, and after
                                        // the final segment start a new pass.
                                        if (seg_sum >= 4'(NUM_SEGMENTS))
                                        begin
                                            seg_new = '0;
                                            rep_new = repeat_reg + 8'd1;
                                        end
                                        else
                                        begin
                                            seg_new = seg_sum[SEG_W-1:0];
                                        end
                                        segment_next = seg_new;
                                        repeat_next  = rep_new;
                                        if (rep_new >= alarm_repeats_reg)
                                        begin
                                            last = 1'b1;
                                        end
                                        else
                                        begin
                                            samples_left_next = seg_length(seg_new);
                                            gain_next         = alarm_gain(rep_new);
                                        end
                                    end
                                end
                            end
                            else
                            begin
                                samples_left_next = count_dec;
                                last              = (count_dec == '0);
                            end
                            if (last)
                            begin
                                mode_next         = MODE_IDLE;
                                samples_left_next = '0;
                            end
                            tick_next.last = last;
                        end
                        default:
                        begin
                            tick_next.phase    = '0;
                            tick_next.gain     = '0;
                            tick_next.sounding = 1'b0;
                            tick_next.last     = 1'b0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            phase_reg        <= '0;
            samples_left_reg <= '0;
            segment_reg      <= '0;
            repeat_reg       <= '0;
            gain_reg         <= '0;
            tick_reg         <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            phase_reg        <= phase_next;
            samples_left_reg <= samples_left_next;
            segment_reg      <= segment_next;
            repeat_reg       <= repeat_next;
            gain_reg         <= gain_next;
            tick_reg         <= tick_next;
        end
    end

    assign tick = tick_reg;

endmodule

// File: rtl/core/dats_sine_rom.sv
module dats_sine_rom import dats_pkg::*; #(
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 silent,
    input  logic [ADDR_BITS-1:0] addr,
    output logic [SAMPLE_W-1:0]  data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [SAMPLE_W-1:0] rom [DEPTH];
    logic [SAMPLE_W-1:0] sample_reg;

    for (genvar a = 0; a < DEPTH; a++)
    begin : g_rom
        assign rom[a] = sine_entry(a, ADDR_BITS);
    end

    // Registered read; a silent tick gives a zero sample.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= silent ? '0 : rom[addr];
        end
    end

    assign data = sample_reg;

endmodule

// File: rtl/core/dds_alarm_tone_sequencer.sv
// Tone generator for an alarm clock, built on direct digital synthesis.
// Commands arrive on the cmd channel: a sample tick, a start of the alarm
// sequence or a start of a beep at a given volume. Each tick transaction
// gives exactly one transaction on the dac channel, carrying the sine sample,
// the amplifier gain lines, a sounding flag and a flag on the final sample of
// an alarm or beep. Start commands and unused codes give no transaction.
// The beep length, the beep phase step and the number of alarm passes are
// written through the cfg_* port; the user must do so only while the block
// is idle, which the block does not enforce. A tick accepted on cmd passes
// the sequencer's tick register and the registered sine table read on its
// way to dac. One command is accepted every cycle while the receiver keeps
// up: phase, counters and gain are updated in the cycle of acceptance.
// When the receiver stalls, the output register and the sequencer's tick
// register fill up and cmd.ready drops; nothing is lost or repeated.
// Reset clears the phase, counters and valid flags at once and loads the
// configuration defaults (beep of 20000 samples at step 750, 127 passes).
module dds_alarm_tone_sequencer import dats_pkg::*; #(
    parameter int SINE_ADDR_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dats_in_if.sink               cmd,
    dats_out_if.source            dac
);

    tick_t tick;
    logic  out_ok;
    logic  advance;
    logic  accept;

    logic  out_valid_reg, out_valid_next;
    logic [GAIN_W-1:0] out_gain_reg;
    logic  out_sounding_reg;
    logic  out_last_reg;
    logic [SAMPLE_W-1:0] rom_data;

    // The output register can take a new tick when it is empty or being
    // drained in this cycle; the tick register then moves forward and can
    // itself take a new command.
    assign out_ok    = !out_valid_reg || dac.ready;
    assign advance   = tick.valid && out_ok;
    assign cmd.ready = !tick.valid || out_ok;
    assign accept    = cmd.valid && cmd.ready;

    dats_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .advance   (advance),
        .func      (cmd.func),
        .volume    (cmd.volume),
        .abort_key (cmd.abort_key),
        .tick      (tick)
    );

    // The top bits of the phase address the sine table.
    dats_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (advance),
        .silent (!tick.sounding),
        .addr   (tick.phase[PHASE_W-1 -: SINE_ADDR_BITS]),
        .data   (rom_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (dac.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_gain_reg     <= tick.gain;
            out_sounding_reg <= tick.sounding;
            out_last_reg     <= tick.last;
        end
    end

    assign dac.valid    = out_valid_reg;
    assign dac.sample   = rom_data;
    assign dac.gain     = out_gain_reg;
    assign dac.sounding = out_sounding_reg;
    assign dac.last     = out_last_reg;

    // An empty output register never holds back the command channel.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cmd.ready)
        else $error("command channel stalled with an empty output register");

    // A tick waiting behind a stalled output keeps its contents.
    a_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && !out_ok) |=> (tick.valid && $stable(tick)))
        else $error("pending tick changed while the output was stalled");

    // A silent transaction carries no sample, no gain and no final mark.
    a_silent_output: assert property (@(posedge clk) disable iff (!rst_n)
        (dac.valid && !dac.sounding) |->
            (dac.sample == '0 && dac.gain == '0 && !dac.last))
        else $error("idle transaction carries sound");

    // The final sample always belongs to an alarm or a beep.
    a_last_sounding: assert property (@(posedge clk) disable iff (!rst_n)
        (dac.valid && dac.last) |-> dac.sounding)
        else $error("final mark on a silent transaction");

endmodule

// File: tb/sv/dds_alarm_tone_sequencer_tb.sv
`timescale 1ns / 100ps

module dds_alarm_tone_sequencer_tb;
    import dats_pkg::*;

    // The testbench works with the block's default table size.
    localparam int ROM_BITS  = 8;
    localparam int ROM_DEPTH = 1 << ROM_BITS;

    // The fourth command code is not in the package. The block must ignore it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int MAX_GAP      = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_LIMIT = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int ALARM_TICKS  = 150;

    typedef enum logic [1:0] {PLAY_IDLE, PLAY_ALARM, PLAY_BEEP} play_mode_t;

    // One DAC transaction, laid out as the fields on the dac channel.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]   gain;
        logic                sounding;
        logic                last;
    } dac_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dats_in_if  cmd_ch ();
    dats_out_if dac_ch ();

    dds_alarm_tone_sequencer #(
        .SINE_ADDR_BITS (ROM_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .dac       (dac_ch)
    );

    // The sine table and the alarm segment tables that the predictor uses.
    logic [SAMPLE_W-1:0] sine_table      [ROM_DEPTH];
    logic [COUNT_W-1:0]  seg_samples_tbl [8];
    logic [PHASE_W-1:0]  seg_incr_tbl    [8];

    // The predictor's copy of the configuration registers.
    logic [COUNT_W-1:0]  beep_len_cfg;
    logic [PHASE_W-1:0]  beep_incr_cfg;
    logic [REPEAT_W-1:0] repeats_cfg;

    // The predictor's copy of the tone state.
    logic [PHASE_W-1:0]  ph_acc;
    logic [COUNT_W-1:0]  remaining;
    logic [SEG_W-1:0]    seg_pos;
    logic [REPEAT_W-1:0] pass_count;
    logic [GAIN_W-1:0]   gain_now;
    play_mode_t          mode;

    // These are the DAC words that are still to come, oldest first.
    dac_word_t pending_samples[$];

    // Each side's idling is switched on or off. A long output hold is requested here.
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_cycles;

    int error_count;
    int report_count;
    int checked_count;
    int tick_count;
    int beeps_started;
    int alarms_started;
    int alarm_passes;
    int holds_done;

    // The clock has a 12 ns period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // This guard ends the run if the handshakes stop moving. It is set well above the
    // slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // This builds the tables. Each sine entry is a rational approximation of the half wave. It
    // is rounded to the nearest integer and clipped at 127.
    task automatic load_tables();
        longint unsigned half;
        longint unsigned t;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        int a;
        half = ROM_DEPTH / 2;
        for (a = 0; a < ROM_DEPTH; a++)
        begin
            t   = longint'(a) % half;
            p   = t * (half - t);
            num = 64'd2032 * p;
            den = 64'd5 * half * half - 64'd4 * p;
            v   = (64'd2 * num + den) / (64'd2 * den);
            if (v > 64'd127)
            begin
                v = 64'd127;
            end
            sine_table[a] = (a < ROM_DEPTH / 2) ? 8'(128 + v) : 8'(128 - v);
        end
        seg_samples_tbl = '{16'd65000, 16'd45000, 16'd35000, 16'd25000,
                            16'd65000, 16'd65000, 16'd65000, 16'd65000};
        seg_incr_tbl    = '{16'd700, 16'd950, 16'd750, 16'd1150,
                            16'd0, 16'd0, 16'd0, 16'd0};
    endtask

    task automatic clear_tone_state();
        beep_len_cfg  = BEEP_LENGTH_RST;
        beep_incr_cfg = BEEP_STEP_RST;
        repeats_cfg   = ALARM_REPEATS_RST;
        ph_acc        = '0;
        remaining     = '0;
        seg_pos       = '0;
        pass_count    = '0;
        gain_now      = '0;
        mode          = PLAY_IDLE;
    endtask

    // This function predicts the effect of one accepted command. It runs at the clock edge
    // where the command transaction completes. A tick gives exactly one DAC word, and
    // start commands and the unused code give none.
    function automatic void apply_command(input logic [FUNC_W-1:0]   f,
                                         input logic [VOLUME_W-1:0] vol,
                                         input logic                abrt);
        logic [PHASE_W-1:0]  incr;
        logic [VOLUME_W-1:0] vol_less;
        dac_word_t           w;
        logic                fin;
        fin      = 1'b0;
        w        = '0;
        vol_less = vol - 8'd1;
        if (f == FUNC_ALARM)
        begin
            // An alarm with no passes configured is ignored.
            if (repeats_cfg != '0)
            begin
                mode       = PLAY_ALARM;
                ph_acc     = '0;
                seg_pos    = '0;
                pass_count = '0;
                remaining  = seg_samples_tbl[0];
                gain_now   = 2'b11;
                alarms_started++;
            end
        end
        else if (f == FUNC_BEEP)
        begin
            // A beep at volume zero or of zero length is ignored. The gain lines
            // take the low two bits of the inverted volume-minus-one.
            if (vol != '0 && beep_len_cfg != '0)
            begin
                mode      = PLAY_BEEP;
                ph_acc    = '0;
                remaining = beep_len_cfg;
                gain_now  = ~vol_less[1:0];
                beeps_started++;
            end
        end
        else if (f == FUNC_TICK)
        begin
            if (mode == PLAY_IDLE)
            begin
                pending_samples.push_back('0);
            end
            else
            begin
                incr       = (mode == PLAY_ALARM) ? seg_incr_tbl[seg_pos] : beep_incr_cfg;
                ph_acc     = ph_acc + incr;
                w.sample   = sine_table[ph_acc[PHASE_W-1 -: ROM_BITS]];
                w.gain     = gain_now;
                w.sounding = 1'b1;
                if (mode == PLAY_ALARM)
                begin
                    // The select key ends the alarm on this sample. Otherwise the segment
                    // counts down. After the last segment the pass count rises and the
                    // gain is reloaded.
                    if (abrt)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        remaining = remaining - 1'b1;
                        if (remaining == '0)
                        begin
                            if (int'(seg_pos) + 1 >= NUM_SEGMENTS)
                            begin
                                seg_pos    = '0;
                                pass_count = pass_count + 1'b1;
                                alarm_passes++;
                            end
                            else
                            begin
                                seg_pos = seg_pos + 1'b1;
                            end
                            if (pass_count >= repeats_cfg)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                remaining = seg_samples_tbl[seg_pos];
                                gain_now  = ~pass_count[6:5];
                            end
                        end
                    end
                end
                else
                begin
                    // The select key does not affect a beep.
                    remaining = remaining - 1'b1;
                    fin       = (remaining == '0);
                end
                if (fin)
                begin
                    mode      = PLAY_IDLE;
                    remaining = '0;
                end
                w.last = fin;
                pending_samples.push_back(w);
            end
        end
    endfunction

    // This task offers one command transaction after a random gap and waits until it is
    // accepted. When no gap is drawn, valid stays high from the previous item, so the
    // block sees a continuous stream.
    task automatic send_cmd(input logic [FUNC_W-1:0]   f,
                            input logic [VOLUME_W-1:0] vol,
                            input logic                abrt);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= f;
        cmd_ch.volume    <= vol;
        cmd_ch.abort_key <= abrt;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        apply_command(f, vol, abrt);
        if (f == FUNC_TICK)
        begin
            tick_count++;
        end
    endtask

    // This task lowers valid and waits for every expected DAC word. It then allows for
    // a start command that may still be in the pipeline.
    task automatic settle_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_BEEP_LENGTH:   beep_len_cfg  = val;
            CFG_BEEP_STEP:     beep_incr_cfg = val;
            CFG_ALARM_REPEATS: repeats_cfg   = val[REPEAT_W-1:0];
            default:           ;
        endcase
    endtask

    // This task writes all three registers on consecutive clock edges once the block has gone quiet.
    task automatic configure(input logic [COUNT_W-1:0]  len,
                             input logic [PHASE_W-1:0]  incr,
                             input logic [REPEAT_W-1:0] reps);
        settle_idle();
        write_reg(CFG_BEEP_LENGTH, len);
        write_reg(CFG_BEEP_STEP, incr);
        write_reg(CFG_ALARM_REPEATS, CFG_DATA_W'(reps));
        cfg_we <= 1'b0;
    endtask

    // Idle behaviour: silent ticks, the unused code and a volume-zero beep. They carry
    // extreme values in fields that the block should ignore.
    task automatic test_idle_and_unused();
        send_cmd(FUNC_TICK, 8'hFF, 1'b1);
        send_cmd(FUNC_UNUSED, 8'hFF, 1'b1);
        send_cmd(FUNC_BEEP, 8'h00, 1'b0);
        send_cmd(FUNC_TICK, 8'h00, 1'b0);
    endtask

    // These are short beeps at the extreme phase steps. They check the gain coding for
    // volumes one and 255, a beep of one sample, and the starts that must be ignored.
    task automatic test_beep_directed();
        configure(16'd3, 16'hFFFF, 8'd255);
        send_cmd(FUNC_BEEP, 8'd1, 1'b1);
        send_cmd(FUNC_TICK, 8'd0, 1'b1);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);

        configure(16'd1, 16'h8000, 8'd0);
        send_cmd(FUNC_ALARM, 8'd0, 1'b0);
        send_cmd(FUNC_BEEP, 8'd255, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);

        configure(16'd0, 16'd0, 8'd1);
        send_cmd(FUNC_BEEP, 8'd2, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
    endtask

    // A start command replaces whatever is playing, including a beep of maximum length.
    // The select key ends an alarm but not a beep.
    task automatic test_replace_and_abort();
        configure(16'hFFFF, 16'd4097, 8'd255);
        send_cmd(FUNC_BEEP, 8'd4, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b1);
        send_cmd(FUNC_ALARM, 8'd0, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
        send_cmd(FUNC_BEEP, 8'd2, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
        send_cmd(FUNC_ALARM, 8'd0, 1'b0);
        send_cmd(FUNC_TICK, 8'd0, 1'b1);
        send_cmd(FUNC_TICK, 8'd0, 1'b0);
    endtask

    // The receiver holds off for a long stretch during a beep while ticks keep arriving.
    // The output register and the tick register fill up, and cmd.ready must drop without
    // any sample being lost or repeated.
    task automatic test_output_backpressure();
        int i;
        configure(16'd30, 16'($urandom), 8'd3);
        send_cmd(FUNC_BEEP, 8'd3, 1'b0);
        rx_hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 45; i++)
        begin
            send_cmd(FUNC_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    // This test streams a long run of alarm ticks without a key press, with both sides
    // working without gaps, and then ends the alarm with the select key. Unused codes
    // are mixed in now and then.
    task automatic test_alarm_stream();
        int i;
        configure(16'd8, 16'd321, 8'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_cmd(FUNC_ALARM, 8'd0, 1'b0);
        for (i = 0; i < ALARM_TICKS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_cmd(FUNC_UNUSED, 8'($urandom), 1'($urandom));
            end
            send_cmd(FUNC_TICK, 8'($urandom), 1'b0);
        end
        send_cmd(FUNC_TICK, 8'd0, 1'b1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // This task runs one random phase. Most of it is beeps and alarms, each followed by a
    // run of ticks with random content. Alarms are ended by an occasional key press. The
    // rest is random commands, including the unused code and volume-zero beeps.
    task automatic run_random_phase(input int n_ticks);
        int ticks_sent;
        int k;
        int i;
        int r;
        int len_cap;
        logic [VOLUME_W-1:0] vol;
        logic [FUNC_W-1:0]   f;
        ticks_sent = 0;
        while (ticks_sent < n_ticks)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                vol = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                send_cmd(FUNC_BEEP, vol, 1'($urandom));
                len_cap = (int'(beep_len_cfg) > 40) ? 40 : int'(beep_len_cfg);
                k = $urandom_range(1, len_cap + 3);
                for (i = 0; i < k; i++)
                begin
                    send_cmd(FUNC_TICK, 8'($urandom), 1'($urandom));
                end
            end
            else if (r < 8)
            begin
                send_cmd(FUNC_ALARM, 8'($urandom), 1'($urandom));
                k = $urandom_range(1, 50);
                for (i = 0; i < k; i++)
                begin
                    send_cmd(FUNC_TICK, 8'($urandom), ($urandom_range(0, 19) == 0));
                end
            end
            else
            begin
                k = 0;
                repeat ($urandom_range(1, 4))
                begin
                    f = 2'($urandom);
                    send_cmd(f, 8'($urandom), 1'($urandom));
                    if (f == FUNC_TICK)
                    begin
                        k++;
                    end
                end
            end
            ticks_sent += k;
        end
    endtask

    // The random phases cover the extremes of every register: beeps of one sample, of zero
    // length and of maximum length, zero and full phase steps, and zero, one and 255
    // alarm passes. Each fourth phase runs with no idling on either side.
    task automatic test_random_traffic();
        int ph;
        logic [COUNT_W-1:0]  len;
        logic [PHASE_W-1:0]  incr;
        logic [REPEAT_W-1:0] reps;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       len = 16'd1;
                3:       len = 16'd0;
                7:       len = 16'hFFFF;
                default: len = 16'($urandom_range(2, 40));
            endcase
            case (ph)
                1:       incr = 16'd0;
                2:       incr = 16'hFFFF;
                default: incr = 16'($urandom);
            endcase
            case (ph)
                4:       reps = 8'd255;
                5:       reps = 8'd0;
                6:       reps = 8'd1;
                default: reps = 8'($urandom_range(1, 254));
            endcase
            configure(len, incr, reps);
            tx_idle_on = (ph % 4 != 3);
            rx_idle_on = (ph % 4 != 3);
            run_random_phase(190);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // This task waits for the last DAC words and watches a few more cycles for stray
    // transactions. It then prints the verdict.
    task automatic finish_run();
        int guard;
        cmd_ch.valid <= 1'b0;
        guard = 0;
        while (pending_samples.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_samples.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected DAC transactions never arrived", $time,
                     pending_samples.size());
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d DAC transactions from %0d ticks: %0d beeps, %0d alarms started,",
                 checked_count, tick_count, beeps_started, alarms_started);
        $display("%0d full alarm passes, %0d long output holds, %0d mismatches.",
                 alarm_passes, holds_done, error_count);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    endtask

    // This is the receiver on the dac channel. It draws a stall for each transaction. It
    // also holds off for a long stretch when a test asks, counting the cycles itself.
    initial
    begin : dac_receiver
        int stall;
        dac_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                dac_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                holds_done++;
            end
            stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            repeat (stall)
            begin
                dac_ch.ready <= 1'b0;
                @(posedge clk);
            end
            dac_ch.ready <= 1'b1;
            @(posedge clk);
            while (!dac_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // Each completed DAC transaction is compared with the oldest expected word. All
    // signals are driven on the clock edge, so the values seen here are the ones present
    // at the edge.
    always @(posedge clk)
    begin
        dac_word_t got;
        dac_word_t want;
        if (rst_n && dac_ch.valid && dac_ch.ready)
        begin
            got = {dac_ch.sample, dac_ch.gain, dac_ch.sounding, dac_ch.last};
            if (pending_samples.size() == 0)
            begin
                error_count++;
                if (report_count < REPORT_LIMIT)
                begin
                    report_count++;
                    $display("%0t: unexpected DAC transaction: expected none, got sample %0d",
                             $time, got.sample, " gain %0d sounding %0b last %0b",
                             got.gain, got.sounding, got.last);
                end
            end
            else
            begin
                want = pending_samples.pop_front();
                checked_count++;
                if (got !== want)
                begin
                    error_count++;
                    if (report_count < REPORT_LIMIT)
                    begin
                        report_count++;
                        $display("%0t: DAC mismatch: expected sample %0d gain %0d", $time,
                                 want.sample, want.gain, " sounding %0b last %0b,",
                                 want.sounding, want.last, " got sample %0d gain %0d",
                                 got.sample, got.gain, " sounding %0b last %0b",
                                 got.sounding, got.last);
                    end
                end
            end
        end
    end

    // This is the main sequence. Reset is held at the start, and the tests then run in turn.
    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.func      <= FUNC_TICK;
        cmd_ch.volume    <= '0;
        cmd_ch.abort_key <= 1'b0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        rx_hold_cycles   = 0;
        error_count      = 0;
        report_count     = 0;
        checked_count    = 0;
        tick_count       = 0;
        beeps_started    = 0;
        alarms_started   = 0;
        alarm_passes     = 0;
        holds_done       = 0;
        load_tables();
        clear_tone_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_unused();
        test_beep_directed();
        test_replace_and_abort();
        test_output_backpressure();
        test_alarm_stream();
        test_random_traffic();
        finish_run();
    end

endmodule

// File: dds_alarm_tone_sequencer.f
rtl/core/dats_pkg.sv
rtl/core/dats_if.sv
rtl/core/dats_seq.sv
rtl/core/dats_sine_rom.sv
rtl/core/dds_alarm_tone_sequencer.sv
tb/sv/dds_alarm_tone_sequencer_tb.sv
